### design/rrbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbg_pkg: shared types and constants
// Word layouts, burst plan and fixed constants of the read-response burst
// generator.
// ----------------------------------------------------------------------------
package rrbg_pkg;

   localparam int REGION_SHIFT = 20;                        // bytes per container: 2^20
   localparam int WORD_BYTES   = 64;
   localparam int WORD_SHIFT   = $clog2(WORD_BYTES);
   localparam int REGION_WORD_SHIFT = REGION_SHIFT - WORD_SHIFT;

   localparam int SIZE_W   = 16;
   localparam int PADDED_W = SIZE_W + 1;                    // holds 65536
   localparam int BEAT_W   = 11;
   localparam int ADDR_W   = 31;
   localparam int KEEP_W   = WORD_BYTES;

   localparam logic [KEEP_W-1:0] KEEP_ALL  = '1;
   localparam logic [4:0]        ACK_SYNDROME = 5'h1F;     // used by the ack header downstream

   localparam logic KIND_DESC    = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;
   localparam logic RESULT_HEADER = 1'b0;
   localparam logic RESULT_BEAT   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [15:0]        container_id;
      logic [31:0]        dest_ip;
      logic [23:0]        queue_pair;
      logic [23:0]        psn;
      logic               first_packet;
      logic               last_packet;
      logic [SIZE_W-1:0]  byte_size;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [31:0]        out_ip;
      logic [23:0]        out_queue_pair;
      logic [1:0]         packet_position;
      logic [15:0]        padded_length;
      logic [1:0]         pad_bytes;
      logic               send_ack_header;
      logic [23:0]        ack_psn;
      logic [ADDR_W-1:0]  word_address;
      logic [KEEP_W-1:0]  keep_mask;
      logic               last_beat;
      logic [15:0]        done_container;
   } rsp_type;

   // burst parameters worked out from one descriptor
   typedef struct packed {
      logic [BEAT_W-1:0]  beat_total;
      logic [KEEP_W-1:0]  final_keep;
      logic [ADDR_W-1:0]  start_word;
   } burst_plan_type;

endpackage
`default_nettype wire

### design/rdma_read_response_burst_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdma_read_response_burst_gen: read-response header and beat generator
// Descriptors give a header word and arm a burst of 64-byte word fetch
// requests; each advance word then gives one beat.
// ----------------------------------------------------------------------------
//
//  channel  direction  word              role
//  req_     in         rrbg_pkg::req_type descriptor (kind 0) or advance (kind 1)
//  rsp_     out        rrbg_pkg::rsp_type header (kind 0) or payload beat (kind 1)
//  csr_     in         32-bit data       base_address register write
//
//  rsp_valid follows a req accept through the input register, then the result
//  register; one req word per cycle is accepted while rsp_ready stays high.
//  A descriptor while a burst is open, or an advance while idle, is dropped
//  and gives no rsp word.
//  Reset (synchronous, active high) empties both registers and closes any burst.
//  A stall on rsp holds the result register and then the input register;
//  req_ready falls only when both are full and rsp_ready is low.
//
module rdma_read_response_burst_gen (
   input  var logic               clock,
   input  var logic               reset,
   input  var logic               req_valid,
   output logic                   req_ready,
   input  var rrbg_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  var logic               rsp_ready,
   output rrbg_pkg::rsp_type      rsp_data,
   input  var logic               csr_valid,
   output logic                   csr_ready,
   input  var logic [31:0]        csr_data
);

   logic [31:0]                base_ff, base_in;
   logic                       s1_valid_ff, s1_valid_in;
   rrbg_pkg::req_type          s1_item_ff, s1_item_in;
   logic                       out_valid_ff, out_valid_in;
   rrbg_pkg::rsp_type          out_data_ff, out_data_in;
   logic                       s1_move;
   logic                       step;
   logic                       produced;
   rrbg_pkg::rsp_type          header;
   rrbg_pkg::rsp_type          result;
   rrbg_pkg::burst_plan_type   plan;

   // config register always takes a write
   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_data : base_ff;

   // stage 1 may hand its word on when the result register is free or draining
   assign s1_move   = !out_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && s1_move;
   assign req_ready = !s1_valid_ff || s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step) begin
         out_valid_in = produced;       // dropped items leave the slot empty
         out_data_in  = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   rrbg_desc_calc u_desc_calc (
      .item         (s1_item_ff),
      .base_address (base_ff),
      .header       (header),
      .plan         (plan)
   );

   rrbg_beat_seq u_beat_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .kind         (s1_item_ff.kind),
      .container_id (s1_item_ff.container_id),
      .header       (header),
      .plan         (plan),
      .produced     (produced),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stage 1 word lost while result register stalled");

   a_no_step_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !step)
      else $error("step taken over an unread result");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

endmodule
`default_nettype wire

### design/rrbg_desc_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbg_desc_calc: descriptor decode
// Builds the header word and the burst plan from one descriptor.
// ----------------------------------------------------------------------------
module rrbg_desc_calc (
   input  var rrbg_pkg::req_type        item,
   input  var logic [31:0]              base_address,
   output rrbg_pkg::rsp_type            header,
   output rrbg_pkg::burst_plan_type     plan
);

   logic [1:0]                                pad;
   logic [rrbg_pkg::PADDED_W-1:0]             padded;
   logic [rrbg_pkg::WORD_SHIFT-1:0]           rem;
   logic [rrbg_pkg::BEAT_W-1:0]               beats;
   logic [rrbg_pkg::ADDR_W-1:0]               base_word;
   logic [rrbg_pkg::ADDR_W-1:0]               region_word;

   // pad to a multiple of four: (4 - size mod 4) mod 4
   assign pad    = 2'(-item.byte_size[1:0]);
   assign padded = {1'b0, item.byte_size} + rrbg_pkg::PADDED_W'(pad);
   assign rem    = padded[rrbg_pkg::WORD_SHIFT-1:0];

   always_comb begin
      beats = rrbg_pkg::BEAT_W'(padded >> rrbg_pkg::WORD_SHIFT)
            + rrbg_pkg::BEAT_W'(rem != '0);
      if (beats == '0) begin
         beats = rrbg_pkg::BEAT_W'(1);     // empty payload still sends one beat
      end
   end

   assign base_word   = rrbg_pkg::ADDR_W'(base_address >> rrbg_pkg::WORD_SHIFT);
   assign region_word = rrbg_pkg::ADDR_W'(item.container_id)
                        << rrbg_pkg::REGION_WORD_SHIFT;

   always_comb begin
      plan.beat_total = beats;
      // partial last word keeps its upper bytes; shift is 64 - rem
      plan.final_keep = (rem == '0) ? rrbg_pkg::KEEP_ALL
                                    : (rrbg_pkg::KEEP_ALL << (-rem));
      plan.start_word = base_word + region_word;
   end

   always_comb begin
      header                 = '0;
      header.result_kind     = rrbg_pkg::RESULT_HEADER;
      header.out_ip          = item.dest_ip;
      header.out_queue_pair  = item.queue_pair;
      header.packet_position = {item.last_packet, item.first_packet};
      header.padded_length   = padded[rrbg_pkg::SIZE_W-1:0];
      header.pad_bytes       = pad;
      header.send_ack_header = item.first_packet | item.last_packet;
      header.ack_psn         = item.psn;
   end

endmodule
`default_nettype wire

### design/rrbg_beat_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbg_beat_seq: burst state and beat generation
// Holds the active burst and turns each step into a header, a beat or
// nothing.
// ----------------------------------------------------------------------------
module rrbg_beat_seq (
   input  var logic                       clock,
   input  var logic                       reset,
   input  var logic                       step,
   input  var logic                       kind,
   input  var logic [15:0]                container_id,
   input  var rrbg_pkg::rsp_type          header,
   input  var rrbg_pkg::burst_plan_type   plan,
   output logic                           produced,
   output rrbg_pkg::rsp_type              result
);

   logic                          busy_ff, busy_in;
   logic [15:0]                   held_container_ff, held_container_in;
   logic [rrbg_pkg::BEAT_W-1:0]   beat_total_ff, beat_total_in;
   logic [rrbg_pkg::BEAT_W-1:0]   beat_index_ff, beat_index_in;
   logic [rrbg_pkg::KEEP_W-1:0]   final_keep_ff, final_keep_in;
   logic [rrbg_pkg::ADDR_W-1:0]   start_word_ff, start_word_in;
   logic [rrbg_pkg::BEAT_W-1:0]   next_index;
   logic                          is_last;

   assign next_index = beat_index_ff + rrbg_pkg::BEAT_W'(1);
   assign is_last    = (next_index == beat_total_ff);

   always_comb begin
      busy_in           = busy_ff;
      held_container_in = held_container_ff;
      beat_total_in     = beat_total_ff;
      beat_index_in     = beat_index_ff;
      final_keep_in     = final_keep_ff;
      start_word_in     = start_word_ff;
      produced          = 1'b0;
      result            = '0;
      if (step && kind == rrbg_pkg::KIND_DESC && !busy_ff) begin
         produced          = 1'b1;
         result            = header;
         busy_in           = 1'b1;
         held_container_in = container_id;
         beat_total_in     = plan.beat_total;
         beat_index_in     = '0;
         final_keep_in     = plan.final_keep;
         start_word_in     = plan.start_word;
      end else if (step && kind == rrbg_pkg::KIND_ADVANCE && busy_ff) begin
         produced            = 1'b1;
         result.result_kind  = rrbg_pkg::RESULT_BEAT;
         result.word_address = start_word_ff + rrbg_pkg::ADDR_W'(beat_index_ff);
         beat_index_in       = next_index;
         if (is_last) begin
            result.keep_mask      = final_keep_ff;
            result.last_beat      = 1'b1;
            result.done_container = held_container_ff;
            busy_in               = 1'b0;
         end else begin
            result.keep_mask = rrbg_pkg::KEEP_ALL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         beat_index_ff <= '0;
      end else begin
         busy_ff       <= busy_in;
         beat_index_ff <= beat_index_in;
      end
      held_container_ff <= held_container_in;
      beat_total_ff     <= beat_total_in;
      final_keep_ff     <= final_keep_in;
      start_word_ff     <= start_word_in;
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> beat_index_ff < beat_total_ff)
      else $error("beat index beyond burst length");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      produced && result.last_beat |=> !busy_ff)
      else $error("burst still active after last beat");

   a_desc_starts_burst: assert property (@(posedge clock) disable iff (reset)
      step && !busy_ff && kind == rrbg_pkg::KIND_DESC
      |=> busy_ff && beat_index_ff == '0)
      else $error("descriptor did not open a burst");

endmodule
`default_nettype wire
